### hdl/rls_pkg.sv
// Shared types, constants and the color wheel for the LED strip serializer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rls_pkg;

  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned TICK_W      = 24;
  localparam int unsigned DUR_W       = 8;
  localparam int unsigned STRIP_W     = 11;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned QUO_W       = 8;
  localparam int unsigned BIT_W       = 5;
  localparam int unsigned STEP_W      = 4;
  localparam logic [STEP_W-1:0] DIV_STEPS = 4'd8;
  localparam logic [BIT_W-1:0]  LAST_BIT  = 5'd23;
  localparam logic [BIT_W-1:0]  BITS_PER_LED = 5'd24;

  localparam logic [7:0]  SEG_ONE = 8'd85;
  localparam logic [7:0]  SEG_TWO = 8'd170;
  localparam logic [7:0]  FULL    = 8'd255;

  localparam logic [DUR_W-1:0]   RST_ONE_HIGH  = 8'd16;
  localparam logic [DUR_W-1:0]   RST_ONE_LOW   = 8'd9;
  localparam logic [DUR_W-1:0]   RST_ZERO_HIGH = 8'd8;
  localparam logic [DUR_W-1:0]   RST_ZERO_LOW  = 8'd17;
  localparam logic [STRIP_W-1:0] RST_STRIP     = 11'd12;
  localparam logic [TICK_W-1:0]  RST_GAP       = 24'd1000000;

  typedef enum logic [1:0] {
    PH_GAP  = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ONE_HIGH  = 3'd0,
    CFG_ONE_LOW   = 3'd1,
    CFG_ZERO_HIGH = 3'd2,
    CFG_ZERO_LOW  = 3'd3,
    CFG_STRIP     = 3'd4,
    CFG_GAP       = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [DUR_W-1:0]  one_high;
    logic [DUR_W-1:0]  one_low;
    logic [DUR_W-1:0]  zero_high;
    logic [DUR_W-1:0]  zero_low;
    logic [TICK_W-1:0] frame_gap;
  } timing_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } q_head_t;

  typedef struct packed {
    logic             ready;
    logic [QUO_W-1:0] quotient;
  } div_stat_t;

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  // Wheel position to packed green, red, blue.
  function automatic logic [COLOR_W-1:0] wheel_grb(input logic [7:0] position);
    logic [7:0] p;
    logic [7:0] s;
    logic [7:0] tri3;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    p = FULL - position;
    if (p < SEG_ONE) begin
      s = p;
    end else if (p < SEG_TWO) begin
      s = p - SEG_ONE;
    end else begin
      s = p - SEG_TWO;
    end
    tri3 = {s[6:0], 1'b0} + s;
    if (p < SEG_ONE) begin
      r = FULL - tri3; g = '0; b = tri3;
    end else if (p < SEG_TWO) begin
      r = '0; g = tri3; b = FULL - tri3;
    end else begin
      r = tri3; g = FULL - tri3; b = '0;
    end
    return {g, r, b};
  endfunction

endpackage

`default_nettype wire

### hdl/rainbow_led_strip_serializer_core.sv
// Top level of the rainbow LED strip serializer: configuration registers,
// tick queue, wheel step divider and waveform engine. Depends on rls_pkg.
// Each tick's result is registered once the engine pops it. Throughput: one
// tick per clock unless the output stalls; the tick that ends an LED waits
// for the 8-step divider, restarted by strip_length writes and LED starts.
// Reset: timing registers take datasheet values, engine starts in the gap.
`default_nettype none

module rainbow_led_strip_serializer_core #(
  parameter int unsigned MAX_LEDS = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             advance_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  line_level_o,
  output logic                                  frame_done_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [rls_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [rls_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_LEDS + 1);

  rls_pkg::timing_t               timing_q;
  logic [rls_pkg::STRIP_W-1:0]    strip_q;
  logic [CNT_W-1:0]               led_count;
  rls_pkg::q_head_t               head;
  logic                           pop;
  logic [IDX_W-1:0]               next_idx;
  rls_pkg::div_stat_t             div_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.one_high  <= rls_pkg::RST_ONE_HIGH;
      timing_q.one_low   <= rls_pkg::RST_ONE_LOW;
      timing_q.zero_high <= rls_pkg::RST_ZERO_HIGH;
      timing_q.zero_low  <= rls_pkg::RST_ZERO_LOW;
      timing_q.frame_gap <= rls_pkg::RST_GAP;
      strip_q            <= rls_pkg::RST_STRIP;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        rls_pkg::CFG_ONE_HIGH:  timing_q.one_high  <= cfg_wdata_i[rls_pkg::DUR_W-1:0];
        rls_pkg::CFG_ONE_LOW:   timing_q.one_low   <= cfg_wdata_i[rls_pkg::DUR_W-1:0];
        rls_pkg::CFG_ZERO_HIGH: timing_q.zero_high <= cfg_wdata_i[rls_pkg::DUR_W-1:0];
        rls_pkg::CFG_ZERO_LOW:  timing_q.zero_low  <= cfg_wdata_i[rls_pkg::DUR_W-1:0];
        rls_pkg::CFG_STRIP:     strip_q            <= cfg_wdata_i[rls_pkg::STRIP_W-1:0];
        rls_pkg::CFG_GAP:       timing_q.frame_gap <= cfg_wdata_i[rls_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp strip length to 1 .. MAX_LEDS
  always_comb begin
    if (strip_q == '0) begin
      led_count = CNT_W'(1);
    end else if (32'(strip_q) > 32'(MAX_LEDS)) begin
      led_count = CNT_W'(32'(MAX_LEDS));
    end else begin
      led_count = CNT_W'(32'(strip_q));
    end
  end

  rls_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .advance_i  (advance_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  rls_divider #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .index_i (next_idx),
    .count_i (led_count),
    .stat_o  (div_stat)
  );

  rls_back #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .timing_i     (timing_q),
    .led_count_i  (led_count),
    .head_i       (head),
    .pop_o        (pop),
    .next_idx_o   (next_idx),
    .div_i        (div_stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_level_o (line_level_o),
    .frame_done_o (frame_done_o)
  );

endmodule

`default_nettype wire

### hdl/rls_front.sv
// Input side of the LED strip serializer: accepts ticks into a two-entry queue.
// Depends on rls_pkg.
`default_nettype none

module rls_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          advance_i,
  output rls_pkg::q_head_t   head_o,
  input  wire logic          pop_i
);

  logic [1:0] store_q;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push;
  logic       pop;

  assign in_ready_o = (fill_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (fill_q != 2'd0);

  assign head_o.valid   = (fill_q != 2'd0);
  assign head_o.advance = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= advance_i;
    end
  end

endmodule

`default_nettype wire

### hdl/rls_divider.sv
// Wheel step unit: floor(index * 256 / count), one quotient bit per cycle.
// Restarts on its own whenever index or count changes. Depends on rls_pkg.
`default_nettype none

module rls_divider #(
  parameter int unsigned IDX_W = 10,
  parameter int unsigned CNT_W = 11
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IDX_W-1:0] index_i,
  input  wire logic [CNT_W-1:0] count_i,
  output rls_pkg::div_stat_t    stat_o
);

  localparam int unsigned REM_W = CNT_W + 1;

  logic [IDX_W-1:0]                 idx_tag_q;
  logic [CNT_W-1:0]                 cnt_tag_q;
  logic [rls_pkg::STEP_W-1:0]       step_q;
  logic [REM_W-1:0]                 rem_q;
  logic [rls_pkg::QUO_W-1:0]        quo_q;
  logic                             stale;
  logic [REM_W-1:0]                 shifted;
  logic                             fits;

  assign stale   = (idx_tag_q != index_i) || (cnt_tag_q != count_i);
  assign shifted = {rem_q[REM_W-2:0], 1'b0};
  assign fits    = (shifted >= REM_W'(count_i));

  assign stat_o.ready    = !stale && (step_q == rls_pkg::DIV_STEPS);
  assign stat_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_tag_q <= '0;
      cnt_tag_q <= '0;
      step_q    <= '0;
    end else if (stale) begin
      idx_tag_q <= index_i;
      cnt_tag_q <= count_i;
      step_q    <= '0;
    end else if (step_q != rls_pkg::DIV_STEPS) begin
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stale) begin
      rem_q <= REM_W'(index_i);
      quo_q <= '0;
    end else if (step_q != rls_pkg::DIV_STEPS) begin
      rem_q <= fits ? (shifted - REM_W'(count_i)) : shifted;
      quo_q <= {quo_q[rls_pkg::QUO_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

### hdl/rls_back.sv
// Waveform engine of the LED strip serializer: phases, bit and LED counters,
// color shift register and the output register. Depends on rls_pkg.
`default_nettype none

module rls_back #(
  parameter int unsigned IDX_W = 10,
  parameter int unsigned CNT_W = 11
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rls_pkg::timing_t   timing_i,
  input  wire logic [CNT_W-1:0]   led_count_i,
  input  wire rls_pkg::q_head_t   head_i,
  output logic                    pop_o,
  output logic [IDX_W-1:0]        next_idx_o,
  input  wire rls_pkg::div_stat_t div_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    line_level_o,
  output logic                    frame_done_o
);

  localparam int unsigned NXT_W = rls_pkg::TICK_W + 1;

  rls_pkg::phase_e                phase_q, phase_d;
  logic [IDX_W-1:0]               led_q, led_d;
  logic [rls_pkg::BIT_W-1:0]      bit_q, bit_d;
  logic [rls_pkg::TICK_W-1:0]     tick_q, tick_d;
  logic [rls_pkg::COLOR_W-1:0]    shift_q, shift_d;
  logic [7:0]                     offset_q, offset_d;
  logic                           out_valid_q, out_valid_d;
  logic                           level_q, level_d;
  logic                           done_q, done_d;

  logic                           can_out;
  logic                           need_quo;
  logic                           step;
  logic                           bit_one;
  logic [NXT_W-1:0]               tick_next;
  logic [rls_pkg::TICK_W-1:0]     dur;
  logic                           dur_end;
  logic [CNT_W:0]                 led_next;
  logic                           last_led;
  logic [rls_pkg::BIT_W-1:0]      bit_next;

  assign can_out    = !out_valid_q || out_ready_i;
  assign need_quo   = (phase_q == rls_pkg::PH_LOW) && (bit_q == rls_pkg::LAST_BIT);
  assign pop_o      = head_i.valid && can_out && (!need_quo || div_i.ready);
  assign step       = pop_o && head_i.advance;

  assign bit_one    = shift_q[rls_pkg::COLOR_W-1];
  assign tick_next  = NXT_W'(tick_q) + NXT_W'(1);
  assign led_next   = (CNT_W+1)'(led_q) + (CNT_W+1)'(1);
  assign last_led   = (led_next >= (CNT_W+1)'(led_count_i));
  assign bit_next   = bit_q + 1'b1;
  assign next_idx_o = led_next[IDX_W-1:0];

  always_comb begin
    unique case (phase_q)
      rls_pkg::PH_HIGH: dur = rls_pkg::TICK_W'(bit_one ? timing_i.one_high
                                                        : timing_i.zero_high);
      rls_pkg::PH_LOW:  dur = rls_pkg::TICK_W'(bit_one ? timing_i.one_low
                                                        : timing_i.zero_low);
      default:          dur = timing_i.frame_gap;
    endcase
  end

  assign dur_end = (tick_next >= NXT_W'(rls_pkg::at_least_one(dur)));

  // Next state
  always_comb begin
    phase_d  = phase_q;
    led_d    = led_q;
    bit_d    = bit_q;
    tick_d   = tick_q;
    shift_d  = shift_q;
    offset_d = offset_q;
    if (step) begin
      tick_d = dur_end ? '0 : tick_next[rls_pkg::TICK_W-1:0];
      unique case (phase_q)
        rls_pkg::PH_HIGH: begin
          if (dur_end) begin
            phase_d = rls_pkg::PH_LOW;
          end
        end
        rls_pkg::PH_LOW: begin
          if (dur_end) begin
            shift_d = {shift_q[rls_pkg::COLOR_W-2:0], 1'b0};
            bit_d   = bit_next;
            phase_d = rls_pkg::PH_HIGH;
            if (bit_next >= rls_pkg::BITS_PER_LED) begin
              bit_d = '0;
              if (last_led) begin
                phase_d = rls_pkg::PH_GAP;
              end else begin
                led_d   = led_next[IDX_W-1:0];
                shift_d = rls_pkg::wheel_grb(offset_q + div_i.quotient);
              end
            end
          end
        end
        default: begin
          if (dur_end) begin
            offset_d = offset_q + 8'd1;
            led_d    = '0;
            bit_d    = '0;
            shift_d  = rls_pkg::wheel_grb(offset_q + 8'd1);
            phase_d  = rls_pkg::PH_HIGH;
          end
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    out_valid_d = out_valid_q;
    level_d     = level_q;
    done_d      = done_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      level_d     = (phase_q == rls_pkg::PH_HIGH);
      done_d      = step && dur_end && (phase_q != rls_pkg::PH_HIGH)
                    && (phase_q != rls_pkg::PH_LOW);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= rls_pkg::PH_GAP;
      led_q       <= '0;
      bit_q       <= '0;
      tick_q      <= '0;
      shift_q     <= '0;
      offset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      led_q       <= led_d;
      bit_q       <= bit_d;
      tick_q      <= tick_d;
      shift_q     <= shift_d;
      offset_q    <= offset_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    done_q  <= done_d;
  end

  assign out_valid_o  = out_valid_q;
  assign line_level_o = level_q;
  assign frame_done_o = done_q;

  a_quo_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && need_quo |-> div_i.ready)
    else $error("LED start taken without a settled wheel step");

  a_done_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> !line_level_o)
    else $error("frame end reported on a high tick");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> bit_q <= rls_pkg::LAST_BIT)
    else $error("bit counter past last bit");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && done_d |=> (phase_q == rls_pkg::PH_HIGH) && (led_q == '0) && (tick_q == '0))
    else $error("frame did not restart at the first LED");

endmodule

`default_nettype wire

### tb/sv/rainbow_led_strip_serializer_core_tb.sv
// Self-checking testbench for rainbow_led_strip_serializer_core: drives ticks and
// register writes, predicts the pin waveform and frame strobes, and compares them.
// Depends on rls_pkg and the core RTL.
`timescale 1ns / 100ps

module rainbow_led_strip_serializer_core_tb;

  localparam int unsigned CLK_PERIOD = 10;

  typedef struct packed {
    logic line_level;
    logic frame_done;
  } pin_t;

  class waveform_scoreboard;
    logic [7:0]       one_high, one_low, zero_high, zero_low;
    logic [10:0]      strip_len;
    logic [23:0]      gap_len;
    logic [7:0]       offset;
    int unsigned      led_idx, bit_idx, ticks;
    rls_pkg::phase_e  ph;
    logic [23:0]      grb;
    pin_t             pending[$];
    int unsigned      errors;

    function new();
      one_high  = 8'd16;
      one_low   = 8'd9;
      zero_high = 8'd8;
      zero_low  = 8'd17;
      strip_len = 11'd12;
      gap_len   = 24'd1000000;
      offset    = '0;
      led_idx   = 0;
      bit_idx   = 0;
      ticks     = 0;
      ph        = rls_pkg::PH_GAP;
      grb       = '0;
      errors    = 0;
    endfunction

    function void set_reg(rls_pkg::cfg_idx_e idx, logic [23:0] data);
      case (idx)
        rls_pkg::CFG_ONE_HIGH:  one_high  = data[7:0];
        rls_pkg::CFG_ONE_LOW:   one_low   = data[7:0];
        rls_pkg::CFG_ZERO_HIGH: zero_high = data[7:0];
        rls_pkg::CFG_ZERO_LOW:  zero_low  = data[7:0];
        rls_pkg::CFG_STRIP:     strip_len = data[10:0];
        rls_pkg::CFG_GAP:       gap_len   = data;
        default: ;
      endcase
    endfunction

    function int unsigned nonzero(int unsigned v);
      return (v == 0) ? 1 : v;
    endfunction

    function int unsigned strip_leds();
      if (strip_len == 0) return 1;
      if (strip_len > 1024) return 1024;
      return strip_len;
    endfunction

    function logic [23:0] hue_grb(int unsigned led);
      int unsigned pos, s, r, g, b;
      pos = 255 - ((offset + led * 256 / strip_leds()) % 256);
      if (pos < 85) begin
        s = pos;
        r = 255 - 3 * s; g = 0; b = 3 * s;
      end else if (pos < 170) begin
        s = pos - 85;
        r = 0; g = 3 * s; b = 255 - 3 * s;
      end else begin
        s = pos - 170;
        r = 3 * s; g = 255 - 3 * s; b = 0;
      end
      return {g[7:0], r[7:0], b[7:0]};
    endfunction

    function void load_led(int unsigned led);
      led_idx = led;
      bit_idx = 0;
      grb     = hue_grb(led);
      ph      = rls_pkg::PH_HIGH;
      ticks   = 0;
    endfunction

    function void take_tick(logic adv);
      pin_t        p;
      int unsigned nxt;
      logic        bitv;
      bitv         = grb[23];
      p.line_level = (ph == rls_pkg::PH_HIGH);
      p.frame_done = 1'b0;
      if (adv) begin
        nxt = ticks + 1;
        case (ph)
          rls_pkg::PH_HIGH: begin
            if (nxt >= nonzero(bitv ? one_high : zero_high)) begin
              ph    = rls_pkg::PH_LOW;
              ticks = 0;
            end else begin
              ticks = nxt;
            end
          end
          rls_pkg::PH_LOW: begin
            if (nxt >= nonzero(bitv ? one_low : zero_low)) begin
              grb     = grb << 1;
              bit_idx = bit_idx + 1;
              ticks   = 0;
              if (bit_idx >= 24) begin
                if (led_idx + 1 >= strip_leds()) begin
                  ph      = rls_pkg::PH_GAP;
                  bit_idx = 0;
                end else begin
                  load_led(led_idx + 1);
                end
              end else begin
                ph = rls_pkg::PH_HIGH;
              end
            end else begin
              ticks = nxt;
            end
          end
          default: begin
            if (nxt >= nonzero(gap_len)) begin
              p.frame_done = 1'b1;
              offset       = offset + 8'd1;
              load_led(0);
            end else begin
              ticks = nxt;
            end
          end
        endcase
      end
      pending.push_back(p);
    endfunction

    function void check_pin(logic lvl, logic done);
      pin_t exp_pin;
      if (pending.size() == 0) begin
        $error("result with nothing pending: line_level %0b frame_done %0b", lvl, done);
        errors++;
        return;
      end
      exp_pin = pending.pop_front();
      if (lvl !== exp_pin.line_level) begin
        $error("line_level: expected %0b, got %0b", exp_pin.line_level, lvl);
        errors++;
      end
      if (done !== exp_pin.frame_done) begin
        $error("frame_done: expected %0b, got %0b", exp_pin.frame_done, done);
        errors++;
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic                           advance_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic                           line_level_o;
  logic                           frame_done_o;
  logic                           cfg_we_i;
  logic [rls_pkg::CFG_ADDR_W-1:0] cfg_addr_i;
  logic [rls_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  waveform_scoreboard book;
  int unsigned        idle_mode;

  rainbow_led_strip_serializer_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .advance_i    (advance_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_level_o (line_level_o),
    .frame_done_o (frame_done_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic bit sender_idles();
    case (idle_mode)
      0: return $urandom_range(99) < 14;
      1: return $urandom_range(99) < 66;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_idles();
    case (idle_mode)
      0: return $urandom_range(99) < 66;
      1: return $urandom_range(99) < 14;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [23:0] pad_upper(int unsigned v, int unsigned w);
    return (24'($urandom) << w) | 24'(v & ((32'd1 << w) - 1));
  endfunction

  task automatic send_tick(input logic adv);
    while (sender_idles()) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    advance_i  = adv;
    do @(posedge clk_i); while (!in_ready_o);
    book.take_tick(adv);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input rls_pkg::cfg_idx_e idx, input logic [23:0] data);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = data;
    @(posedge clk_i);
    book.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_timing(input int unsigned oh, ol, zh, zl, strip, gap);
    write_reg(rls_pkg::CFG_ONE_HIGH, pad_upper(oh, 8));
    write_reg(rls_pkg::CFG_ONE_LOW, pad_upper(ol, 8));
    write_reg(rls_pkg::CFG_ZERO_HIGH, pad_upper(zh, 8));
    write_reg(rls_pkg::CFG_ZERO_LOW, pad_upper(zl, 8));
    write_reg(rls_pkg::CFG_STRIP, pad_upper(strip, 11));
    write_reg(rls_pkg::CFG_GAP, 24'(gap));
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (book.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin : result_sink
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      out_ready_i = !receiver_idles();
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) book.check_pin(line_level_o, frame_done_o);
    end
  end

  initial begin : stimulus
    logic [18:0] pattern;
    int unsigned quota, sent;
    logic        adv;
    book        = new();
    idle_mode   = 2;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    advance_i   = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = rls_pkg::CFG_ONE_HIGH;
    cfg_wdata_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_tick(1'b0);
    repeat (5) send_tick(1'b1);
    drain_results();
    // zero counts and zero strip length all act as one
    set_timing(0, 0, 0, 0, 0, 0);
    pattern = 19'b1101110111100111011;
    for (int i = 18; i >= 0; i--) send_tick(pattern[i]);

    for (int p = 0; p < 8; p++) begin
      drain_results();
      idle_mode = p * 3 / 8;
      case (p)
        0: begin
          set_timing(1, 1, 1, 1, 1, 1);
          quota = 180;
        end
        1: begin
          set_timing($urandom_range(3, 1), $urandom_range(3, 1), $urandom_range(3, 1),
                     $urandom_range(3, 1), $urandom_range(5, 1), $urandom_range(3, 0));
          quota = 120;
        end
        2: begin
          set_timing(0, 0, 0, 0, 2047, 0);
          quota = 100;
        end
        3: begin
          set_timing(255, 255, 255, 255, 1024, 24'hFFFFFF);
          quota = 60;
        end
        4: begin
          set_timing($urandom_range(2, 0), $urandom_range(2, 0), $urandom_range(2, 0),
                     $urandom_range(2, 0), $urandom_range(3, 0), $urandom_range(2, 0));
          quota = 160;
        end
        5: begin
          set_timing(255, 1, 1, 255, 3, 1000);
          quota = 80;
        end
        6: begin
          set_timing(1, 1, 1, 1, $urandom_range(2, 1), 1);
          quota = 180;
        end
        default: begin
          set_timing($urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(4, 1),
                     $urandom_range(4, 1), $urandom_range(1100, 1), $urandom_range(5, 0));
          quota = 120;
        end
      endcase
      sent = 0;
      while (sent < quota) begin
        adv = ($urandom_range(9) != 0);
        send_tick(adv);
        if (adv) sent++;
      end
    end

    drain_results();
    repeat (20) @(negedge clk_i);
    if (book.errors == 0 && book.pending.size() == 0) begin
      $display("rainbow_led_strip_serializer_core_tb OK");
    end else begin
      $display("rainbow_led_strip_serializer_core_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(3_000_000);
    $display("rainbow_led_strip_serializer_core_tb NOT OK");
    $finish;
  end

endmodule

### rainbow_led_strip_serializer_core.f
hdl/rls_pkg.sv
hdl/rls_front.sv
hdl/rls_divider.sv
hdl/rls_back.sv
hdl/rainbow_led_strip_serializer_core.sv
tb/sv/rainbow_led_strip_serializer_core_tb.sv
